/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the bitstream reader RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RBBR_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`define RBBR_ASSERT_NEVER(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) else $error(msg);
`else
`define RBBR_ASSERT(label, clk, rstn, prop, msg)
`define RBBR_ASSERT_NEVER(label, clk, rstn, expr, msg)
`endif
`endif

/* design/rbbr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbbr_pkg
// Types and constants of the ring buffer bitstream reader.
// ----------------------------------------------------------------------------
package rbbr_pkg;

    localparam int MEM_DEPTH   = 4096;
    localparam int ADDR_W      = 12;
    localparam int LEN_W       = 13;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_INDEX_W = 1;
    localparam int KIND_W      = 3;
    localparam int BYTE_W      = 8;
    localparam int OPERAND_W   = 32;
    localparam int VALUE_W     = 32;
    localparam int ACC_W       = 64;
    localparam int CNT_W       = 7;
    localparam int NBITS_W     = 6;
    localparam int END_W       = 14;
    localparam int END2_W      = 15;

    localparam logic [CNT_W-1:0]   REFILL_LIMIT = 7'd56;
    localparam logic [CNT_W-1:0]   BYTE_BITS    = 7'd8;
    localparam logic [NBITS_W-1:0] MAX_PEEK     = 6'd32;
    localparam logic [LEN_W-1:0]   RING_LENGTH_RESET = 13'd4096;

    localparam logic [CFG_INDEX_W-1:0] REG_RING_BASE   = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RING_LENGTH = 1'd1;

    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE  = 3'd0,
        KIND_START  = 3'd1,
        KIND_PEEK   = 3'd2,
        KIND_FLUSH  = 3'd3,
        KIND_GET    = 3'd4,
        KIND_SKIP   = 3'd5,
        KIND_LOCATE = 3'd6
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_ADDR,
        ST_WRAP,
        ST_REFILL,
        ST_RESULT
    } state_t;

endpackage

/* design/rbbr_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbbr_ram
// Generic single-port RAM with a registered read.
// ----------------------------------------------------------------------------
module rbbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

/* design/ring_buffer_bitstream_reader.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_buffer_bitstream_reader
// Bit reader over a byte ring buffer kept in an internal single-port RAM.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake           Payload
// cfg       in         cfg_wr_en           cfg_index, cfg_wdata
// s_        in         s_valid / s_ready   kind, address, data, operand
// m_        out        m_valid / m_ready   bits_value, total_bits, byte_address,
//                                          out_of_range
//
// One transaction is handled at a time. Write and peek pass the execute state
// to the result register; flush and get also pass the refill state. Start and
// skip refill eight bytes; skip and locate first form an address in the address
// and wrap states. The single RAM port, read one byte per cycle, sets the refill
// time. Reset is synchronous and needs no clearing pass. A result waiting on
// m_ready stalls only the next transaction's completion.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ring_buffer_bitstream_reader #(
    parameter int TOTAL_WIDTH = 32
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [rbbr_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [rbbr_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [rbbr_pkg::KIND_W-1:0]          s_kind,
    input  logic [rbbr_pkg::ADDR_W-1:0]          s_address,
    input  logic [rbbr_pkg::BYTE_W-1:0]          s_data,
    input  logic [rbbr_pkg::OPERAND_W-1:0]       s_operand,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [rbbr_pkg::VALUE_W-1:0]         m_bits_value,
    output logic [rbbr_pkg::VALUE_W-1:0]         m_total_bits,
    output logic [rbbr_pkg::ADDR_W-1:0]          m_byte_address,
    output logic                                 m_out_of_range
);

    localparam int TW      = TOTAL_WIDTH;
    localparam int SW      = (TW > 35) ? TW : 35;
    localparam int SHIFT_W = (TW - 3 > 29) ? TW - 3 : 29;
    localparam int VW      = SHIFT_W + 1;

    rbbr_pkg::state_t state_reg, state_next;

    logic [rbbr_pkg::KIND_W-1:0]    kind_reg, kind_next;
    logic [rbbr_pkg::OPERAND_W-1:0] operand_reg, operand_next;
    logic [rbbr_pkg::ACC_W-1:0]     acc_reg, acc_next;
    logic [rbbr_pkg::CNT_W-1:0]     valid_reg, valid_next;
    logic [rbbr_pkg::CNT_W-1:0]     proj_reg, proj_next;
    logic [rbbr_pkg::ADDR_W-1:0]    rp_reg, rp_next;
    logic [rbbr_pkg::ADDR_W-1:0]    start_reg, start_next;
    logic [TW-1:0]                  total_reg, total_next;
    logic [rbbr_pkg::VALUE_W-1:0]   value_reg, value_next;
    logic                           oor_reg, oor_next;
    logic [rbbr_pkg::ADDR_W-1:0]    loc_reg, loc_next;
    logic [VW-1:0]                  v_reg, v_next;
    logic                           rd_pend_reg, rd_pend_next;
    logic [rbbr_pkg::ADDR_W-1:0]    ring_base_reg, ring_base_next;
    logic [rbbr_pkg::LEN_W-1:0]     ring_length_reg, ring_length_next;

    logic                           m_valid_reg, m_valid_next;
    logic [rbbr_pkg::VALUE_W-1:0]   m_bits_value_reg, m_bits_value_next;
    logic [rbbr_pkg::VALUE_W-1:0]   m_total_bits_reg, m_total_bits_next;
    logic [rbbr_pkg::ADDR_W-1:0]    m_byte_address_reg, m_byte_address_next;
    logic                           m_out_of_range_reg, m_out_of_range_next;

    logic                           ram_we;
    logic [rbbr_pkg::ADDR_W-1:0]    ram_addr;
    logic [rbbr_pkg::BYTE_W-1:0]    ram_rdata;

    logic [rbbr_pkg::END_W-1:0]     ring_end;
    logic [rbbr_pkg::END2_W-1:0]    ring_end2;
    logic                           refill_issue;
    logic                           out_free;
    logic [rbbr_pkg::NBITS_W-1:0]   nbits;
    logic [rbbr_pkg::VALUE_W-1:0]   peek_value;
    logic [rbbr_pkg::CNT_W-1:0]     valid_flushed;
    logic [SW-1:0]                  skip_sum;
    logic [VW-1:0]                  v_wrapped;
    logic [rbbr_pkg::LEN_W-1:0]     rp_inc;
    logic [rbbr_pkg::ADDR_W-1:0]    rp_adv;
    logic [rbbr_pkg::CNT_W-1:0]     merge_shift;
    logic [rbbr_pkg::ACC_W-1:0]     merge_bits;
    logic [63:0]                    total_ext;

    rbbr_ram #(
        .WIDTH (rbbr_pkg::BYTE_W),
        .DEPTH (rbbr_pkg::MEM_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (s_data),
        .rdata (ram_rdata)
    );

    assign s_ready        = (state_reg == rbbr_pkg::ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_bits_value   = m_bits_value_reg;
    assign m_total_bits   = m_total_bits_reg;
    assign m_byte_address = m_byte_address_reg;
    assign m_out_of_range = m_out_of_range_reg;

    assign ring_end     = rbbr_pkg::END_W'(ring_base_reg) + rbbr_pkg::END_W'(ring_length_reg);
    assign ring_end2    = rbbr_pkg::END2_W'(ring_end) + rbbr_pkg::END2_W'(ring_length_reg);
    assign refill_issue = (proj_reg <= rbbr_pkg::REFILL_LIMIT);
    assign out_free     = !m_valid_reg || m_ready;

    assign nbits = ((|operand_reg[31:6]) || (operand_reg[5:0] > rbbr_pkg::MAX_PEEK))
                   ? rbbr_pkg::MAX_PEEK : operand_reg[5:0];
    assign peek_value    = acc_reg[63:32] >> (rbbr_pkg::MAX_PEEK - nbits);
    assign valid_flushed = (valid_reg >= rbbr_pkg::CNT_W'(nbits))
                           ? valid_reg - rbbr_pkg::CNT_W'(nbits) : '0;
    assign skip_sum      = SW'(total_reg) + SW'({operand_reg, 3'b000});

    assign v_wrapped = (v_reg >= VW'(ring_end)) ? v_reg - VW'(ring_length_reg) : v_reg;

    assign rp_inc = rbbr_pkg::LEN_W'(rp_reg) + rbbr_pkg::LEN_W'(1);
    assign rp_adv = (rbbr_pkg::END_W'(rp_inc) >= ring_end) ? ring_base_reg
                                                           : rp_inc[rbbr_pkg::ADDR_W-1:0];

    assign merge_shift = rbbr_pkg::REFILL_LIMIT - valid_reg;
    assign merge_bits  = rbbr_pkg::ACC_W'(ram_rdata) << merge_shift[5:0];
    assign total_ext   = 64'(total_reg);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rbbr_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = rbbr_pkg::ST_EXEC;
                end
            end
            rbbr_pkg::ST_EXEC: begin
                unique case (kind_reg)
                    rbbr_pkg::KIND_START,
                    rbbr_pkg::KIND_FLUSH,
                    rbbr_pkg::KIND_GET:    state_next = rbbr_pkg::ST_REFILL;
                    rbbr_pkg::KIND_SKIP,
                    rbbr_pkg::KIND_LOCATE: state_next = rbbr_pkg::ST_ADDR;
                    default:               state_next = rbbr_pkg::ST_RESULT;
                endcase
            end
            rbbr_pkg::ST_ADDR: begin
                state_next = rbbr_pkg::ST_WRAP;
            end
            rbbr_pkg::ST_WRAP: begin
                if (kind_reg == rbbr_pkg::KIND_LOCATE) begin
                    state_next = rbbr_pkg::ST_RESULT;
                end else begin
                    state_next = rbbr_pkg::ST_REFILL;
                end
            end
            rbbr_pkg::ST_REFILL: begin
                if (!refill_issue && !rd_pend_reg) begin
                    state_next = rbbr_pkg::ST_RESULT;
                end
            end
            rbbr_pkg::ST_RESULT: begin
                if (out_free) begin
                    state_next = rbbr_pkg::ST_IDLE;
                end
            end
            default: state_next = rbbr_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        kind_next           = kind_reg;
        operand_next        = operand_reg;
        acc_next            = acc_reg;
        valid_next          = valid_reg;
        proj_next           = proj_reg;
        rp_next             = rp_reg;
        start_next          = start_reg;
        total_next          = total_reg;
        value_next          = value_reg;
        oor_next            = oor_reg;
        loc_next            = loc_reg;
        v_next              = v_reg;
        rd_pend_next        = 1'b0;
        ring_base_next      = ring_base_reg;
        ring_length_next    = ring_length_reg;
        m_valid_next        = m_valid_reg && !m_ready;
        m_bits_value_next   = m_bits_value_reg;
        m_total_bits_next   = m_total_bits_reg;
        m_byte_address_next = m_byte_address_reg;
        m_out_of_range_next = m_out_of_range_reg;
        ram_we              = 1'b0;
        ram_addr            = rp_reg;

        if (cfg_wr_en) begin
            unique case (cfg_index)
                rbbr_pkg::REG_RING_BASE:   ring_base_next   = cfg_wdata[rbbr_pkg::ADDR_W-1:0];
                rbbr_pkg::REG_RING_LENGTH: ring_length_next = cfg_wdata;
                default: ;
            endcase
        end

        unique case (state_reg)
            rbbr_pkg::ST_IDLE: begin
                if (s_valid) begin
                    kind_next    = s_kind;
                    operand_next = s_operand;
                    if (s_kind == rbbr_pkg::KIND_WRITE) begin
                        ram_we   = 1'b1;
                        ram_addr = s_address;
                    end
                end
            end
            rbbr_pkg::ST_EXEC: begin
                value_next = '0;
                oor_next   = 1'b0;
                unique case (kind_reg)
                    rbbr_pkg::KIND_START: begin
                        start_next = operand_reg[rbbr_pkg::ADDR_W-1:0];
                        rp_next    = operand_reg[rbbr_pkg::ADDR_W-1:0];
                        acc_next   = '0;
                        valid_next = '0;
                        proj_next  = '0;
                        total_next = '0;
                    end
                    rbbr_pkg::KIND_PEEK: begin
                        value_next = peek_value;
                    end
                    rbbr_pkg::KIND_FLUSH,
                    rbbr_pkg::KIND_GET: begin
                        if (kind_reg == rbbr_pkg::KIND_GET) begin
                            value_next = peek_value;
                        end
                        acc_next   = acc_reg << nbits;
                        valid_next = valid_flushed;
                        proj_next  = valid_flushed;
                        total_next = total_reg + TW'(nbits);
                    end
                    rbbr_pkg::KIND_SKIP: begin
                        acc_next   = '0;
                        valid_next = '0;
                        proj_next  = '0;
                        total_next = skip_sum[TW-1:0];
                    end
                    default: ;
                endcase
            end
            rbbr_pkg::ST_ADDR: begin
                if (kind_reg == rbbr_pkg::KIND_LOCATE) begin
                    v_next = VW'(start_reg) + VW'(operand_reg[rbbr_pkg::OPERAND_W-1:3]);
                end else begin
                    v_next = VW'(start_reg) + VW'(total_reg[TW-1:3]);
                end
            end
            rbbr_pkg::ST_WRAP: begin
                oor_next = (VW'(ring_end2) <= v_reg);
                if (kind_reg == rbbr_pkg::KIND_LOCATE) begin
                    loc_next = v_wrapped[rbbr_pkg::ADDR_W-1:0];
                end else begin
                    rp_next = v_wrapped[rbbr_pkg::ADDR_W-1:0];
                end
            end
            rbbr_pkg::ST_REFILL: begin
                if (refill_issue) begin
                    rp_next      = rp_adv;
                    proj_next    = proj_reg + rbbr_pkg::BYTE_BITS;
                    rd_pend_next = 1'b1;
                end
                if (rd_pend_reg) begin
                    acc_next   = acc_reg | merge_bits;
                    valid_next = valid_reg + rbbr_pkg::BYTE_BITS;
                end
            end
            rbbr_pkg::ST_RESULT: begin
                if (out_free) begin
                    m_valid_next        = 1'b1;
                    m_bits_value_next   = value_reg;
                    m_total_bits_next   = total_ext[rbbr_pkg::VALUE_W-1:0];
                    m_byte_address_next = (kind_reg == rbbr_pkg::KIND_LOCATE) ? loc_reg : rp_reg;
                    m_out_of_range_next = oor_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= rbbr_pkg::ST_IDLE;
            acc_reg         <= '0;
            valid_reg       <= '0;
            rp_reg          <= '0;
            start_reg       <= '0;
            total_reg       <= '0;
            rd_pend_reg     <= 1'b0;
            ring_base_reg   <= '0;
            ring_length_reg <= rbbr_pkg::RING_LENGTH_RESET;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            acc_reg         <= acc_next;
            valid_reg       <= valid_next;
            rp_reg          <= rp_next;
            start_reg       <= start_next;
            total_reg       <= total_next;
            rd_pend_reg     <= rd_pend_next;
            ring_base_reg   <= ring_base_next;
            ring_length_reg <= ring_length_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg           <= kind_next;
        operand_reg        <= operand_next;
        proj_reg           <= proj_next;
        value_reg          <= value_next;
        oor_reg            <= oor_next;
        loc_reg            <= loc_next;
        v_reg              <= v_next;
        m_bits_value_reg   <= m_bits_value_next;
        m_total_bits_reg   <= m_total_bits_next;
        m_byte_address_reg <= m_byte_address_next;
        m_out_of_range_reg <= m_out_of_range_next;
    end

    `RBBR_ASSERT(a_rd_after_refill, aclk, aresetn, rd_pend_reg |-> ($past(state_reg) == rbbr_pkg::ST_REFILL), "RAM read data pending outside a refill")
    `RBBR_ASSERT(a_we_in_idle, aclk, aresetn, ram_we |-> (state_reg == rbbr_pkg::ST_IDLE), "RAM written outside an accepted write transaction")
    `RBBR_ASSERT(a_oor_kind, aclk, aresetn, (state_reg == rbbr_pkg::ST_RESULT && out_free && oor_reg) |-> (kind_reg == rbbr_pkg::KIND_SKIP || kind_reg == rbbr_pkg::KIND_LOCATE), "Range flag raised for a transaction that computes no address")
    `RBBR_ASSERT_NEVER(a_valid_bound, aclk, aresetn, valid_reg > 7'd64, "Accumulator valid count exceeds its width")

endmodule
